[design/paged_bump_allocator_assert.svh]
// assertion macros for the paged bump allocator
`ifndef PAGED_BUMP_ALLOCATOR_ASSERT_SVH
`define PAGED_BUMP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge outside reset
`define PBA_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("paged bump allocator check failed");

// trigger implies consequence in the next cycle
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("paged bump allocator sequence check failed");

`else

`define PBA_ASSERT(lbl, clk, rst_n, cond)
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)

`endif

`endif

[design/pba_pkg.sv]
// constants shared by the paged bump allocator
`default_nettype none

package pba_pkg;

  localparam int DEFAULT_MAX_PAGES = 16;

  localparam int SIZE_W   = 13;
  localparam int HDR_W    = 8;
  localparam int PAGE_W   = 4;
  localparam int OFFSET_W = 12;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0]   PAGE_LIMIT   = 13'd4096;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 12'hFFF;
  localparam logic [SIZE_W-1:0]   RESET_PAGE_SIZE = 13'd4096;
  localparam logic [HDR_W-1:0]    RESET_HEADER    = 8'd24;

  localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 2'd1;

endpackage

`default_nettype wire

[design/paged_bump_allocator.sv]
// Paged bump allocator: one request at a time, pages searched newest to oldest through one
// page-use memory and a single room compare. On accept the size is checked against the page
// capacity and the newest page is read; the pages are then visited one by one, as the memory
// gives one page's use per cycle, and at last the result is loaded into the output register.
// A request larger than the capacity goes to the output register without a page search.
// in_stall is high from accept until the result has been moved to the output register; that
// register holds while out_stall is high.
`default_nettype none

`include "paged_bump_allocator_assert.svh"

module paged_bump_allocator #(
  parameter int MAX_PAGES = pba_pkg::DEFAULT_MAX_PAGES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pba_pkg::SIZE_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pba_pkg::SIZE_W-1:0]     in_request_size,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pba_pkg::PAGE_W-1:0]          out_page_index,
  output logic [pba_pkg::OFFSET_W-1:0]        out_byte_offset,
  output logic                                out_opened_page,
  output logic [pba_pkg::STATUS_W-1:0]        out_status
);

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int SW = pba_pkg::SIZE_W;
  localparam int HW = pba_pkg::HDR_W;
  localparam int PW = pba_pkg::PAGE_W;
  localparam int OW = pba_pkg::OFFSET_W;
  localparam int TW = pba_pkg::STATUS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_PEND
  } state_t;

  state_t          state_r, state_nxt;
  logic [SW-1:0]   page_size_r, page_size_nxt;
  logic [HW-1:0]   header_r, header_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            p0_written_r, p0_written_nxt;
  logic [SW-1:0]   size_r, size_nxt;
  logic [SW-1:0]   cap_r, cap_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [PW-1:0]   res_page_r, res_page_nxt;
  logic [OW-1:0]   res_off_r, res_off_nxt;
  logic            res_open_r, res_open_nxt;
  logic [TW-1:0]   res_status_r, res_status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [PW-1:0]   out_page_r, out_page_nxt;
  logic [OW-1:0]   out_off_r, out_off_nxt;
  logic            out_open_r, out_open_nxt;
  logic [TW-1:0]   out_status_r, out_status_nxt;

  // page use memory
  logic [SW-1:0]   used_mem [MAX_PAGES];
  logic [SW-1:0]   rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [SW-1:0]   mem_wd;

  logic            in_beat;
  logic [SW-1:0]   ps_c;
  logic [SW-1:0]   cap_c;
  logic            too_big_c;
  logic [CW-1:0]   count_m1;
  logic [SW-1:0]   used_c;
  logic [SW-1:0]   room_c;
  logic            fit_c;
  logic [SW:0]     off_sum;
  logic [OW-1:0]   off_c;
  logic [AW+PW-1:0] cur_ext;
  logic [CW+PW-1:0] count_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_beat   = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_page_index  = out_page_r;
  assign out_byte_offset = out_off_r;
  assign out_opened_page = out_open_r;
  assign out_status      = out_status_r;

  // capacity from current registers, clamped page size
  assign ps_c      = (page_size_r > pba_pkg::PAGE_LIMIT) ? pba_pkg::PAGE_LIMIT : page_size_r;
  assign cap_c     = (ps_c > {{(SW-HW){1'b0}}, header_r}) ?
                     (ps_c - {{(SW-HW){1'b0}}, header_r}) : '0;
  assign too_big_c = (in_request_size > cap_c);
  assign count_m1  = count_r - {{(CW-1){1'b0}}, 1'b1};

  // shared room check on the page just read
  assign used_c  = ((cur_r == '0) && !p0_written_r) ? '0 : rd_data_r;
  assign room_c  = (cap_r > used_c) ? (cap_r - used_c) : '0;
  assign fit_c   = (size_r <= room_c);
  assign off_sum = {{(SW+1-HW){1'b0}}, header_r} + {1'b0, used_c};
  assign off_c   = (off_sum > {{(SW+1-OW){1'b0}}, pba_pkg::OFFSET_MAX}) ?
                   pba_pkg::OFFSET_MAX : off_sum[OW-1:0];

  assign cur_ext   = {{PW{1'b0}}, cur_r};
  assign count_ext = {{PW{1'b0}}, count_r};

  always_comb begin
    rd_addr = cur_r;
    if (state_r == S_IDLE) begin
      rd_addr = count_m1[AW-1:0];
    end else if (state_r == S_SEARCH) begin
      rd_addr = cur_r - {{(AW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= used_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    page_size_nxt  = page_size_r;
    header_nxt     = header_r;
    count_nxt      = count_r;
    p0_written_nxt = p0_written_r;
    size_nxt       = size_r;
    cap_nxt        = cap_r;
    cur_nxt        = cur_r;
    res_page_nxt   = res_page_r;
    res_off_nxt    = res_off_r;
    res_open_nxt   = res_open_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_page_nxt   = out_page_r;
    out_off_nxt    = out_off_r;
    out_open_nxt   = out_open_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = cur_r;
    mem_wd         = used_c + size_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pba_pkg::REG_PAGE_SIZE: page_size_nxt = cfg_data;
        pba_pkg::REG_HEADER:    header_nxt    = cfg_data[HW-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          size_nxt = in_request_size;
          cap_nxt  = cap_c;
          cur_nxt  = count_m1[AW-1:0];
          if (too_big_c) begin
            res_page_nxt   = '0;
            res_off_nxt    = '0;
            res_open_nxt   = 1'b0;
            res_status_nxt = pba_pkg::ST_TOO_BIG;
            state_nxt      = S_PEND;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (fit_c) begin
          mem_we         = 1'b1;
          mem_wa         = cur_r;
          mem_wd         = used_c + size_r;
          if (cur_r == '0) begin
            p0_written_nxt = 1'b1;
          end
          res_page_nxt   = cur_ext[PW-1:0];
          res_off_nxt    = off_c;
          res_open_nxt   = 1'b0;
          res_status_nxt = pba_pkg::ST_GRANTED;
          state_nxt      = S_PEND;
        end else if (cur_r == '0) begin
          // oldest page full too: open the next one or give up
          if (count_r < CW'(MAX_PAGES)) begin
            mem_we         = 1'b1;
            mem_wa         = count_r[AW-1:0];
            mem_wd         = size_r;
            count_nxt      = count_r + {{(CW-1){1'b0}}, 1'b1};
            res_page_nxt   = count_ext[PW-1:0];
            res_off_nxt    = {{(OW-HW){1'b0}}, header_r};
            res_open_nxt   = 1'b1;
            res_status_nxt = pba_pkg::ST_GRANTED;
          end else begin
            res_page_nxt   = '0;
            res_off_nxt    = '0;
            res_open_nxt   = 1'b0;
            res_status_nxt = pba_pkg::ST_NO_PAGE;
          end
          state_nxt = S_PEND;
        end else begin
          cur_nxt = cur_r - {{(AW-1){1'b0}}, 1'b1};
        end
      end
      S_PEND: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_page_nxt   = res_page_r;
          out_off_nxt    = res_off_r;
          out_open_nxt   = res_open_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      page_size_r  <= pba_pkg::RESET_PAGE_SIZE;
      header_r     <= pba_pkg::RESET_HEADER;
      count_r      <= {{(CW-1){1'b0}}, 1'b1};
      p0_written_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      page_size_r  <= page_size_nxt;
      header_r     <= header_nxt;
      count_r      <= count_nxt;
      p0_written_r <= p0_written_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    size_r       <= size_nxt;
    cap_r        <= cap_nxt;
    cur_r        <= cur_nxt;
    res_page_r   <= res_page_nxt;
    res_off_r    <= res_off_nxt;
    res_open_r   <= res_open_nxt;
    res_status_r <= res_status_nxt;
    out_page_r   <= out_page_nxt;
    out_off_r    <= out_off_nxt;
    out_open_r   <= out_open_nxt;
    out_status_r <= out_status_nxt;
  end

  `PBA_ASSERT(a_count_range, clk, rst_n, (count_r != '0) && (count_r <= CW'(MAX_PAGES)))
  `PBA_ASSERT(a_search_in_open, clk, rst_n, (state_r != S_SEARCH) || (cur_r < count_r[AW-1:0]) || (count_r == CW'(MAX_PAGES)))
  `PBA_ASSERT_NEXT(a_too_big_flag, clk, rst_n, in_beat && too_big_c, (state_r == S_PEND) && (res_status_r == pba_pkg::ST_TOO_BIG))
  `PBA_ASSERT_NEXT(a_count_from_search, clk, rst_n, (state_r != S_SEARCH), $stable(count_r))

endmodule

`default_nettype wire

[tb/pba_grant_check_pkg.sv]
// allocation predictor and result checker for the paged bump allocator bench
package pba_grant_check_pkg;

  import pba_pkg::*;

  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic                opened;
    logic [STATUS_W-1:0] status;
  } grant_t;

  class grant_checker;

    logic [SIZE_W-1:0] page_size;
    logic [HDR_W-1:0]  header;
    logic [SIZE_W-1:0] page_use [DEFAULT_MAX_PAGES];
    int unsigned       open_pages;
    grant_t            expected_grants [$];
    int unsigned       mismatches;

    function new();
      page_size = RESET_PAGE_SIZE;
      header = RESET_HEADER;
      foreach (page_use[i]) page_use[i] = '0;
      open_pages = 1;
      mismatches = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      if (idx == REG_PAGE_SIZE) page_size = data;
      else if (idx == REG_HEADER) header = data[HDR_W-1:0];
    endfunction

    // usable bytes per page after the header
    function int unsigned capacity();
      int unsigned ps;
      int unsigned hdr;
      ps = 32'((page_size > PAGE_LIMIT) ? PAGE_LIMIT : page_size);
      hdr = 32'(header);
      return (ps > hdr) ? ps - hdr : 0;
    endfunction

    function void note_request(logic [SIZE_W-1:0] size);
      grant_t      g;
      int unsigned cap;
      int unsigned used;
      int unsigned room;
      int unsigned off;
      int          p;
      bit          placed;
      cap = capacity();
      g = '0;
      g.status = ST_GRANTED;
      placed = 1'b0;
      if (32'(size) > cap) begin
        g.status = ST_TOO_BIG;
      end else begin
        // newest open page first
        for (p = int'(open_pages) - 1; p >= 0 && !placed; p--) begin
          used = 32'(page_use[p]);
          room = (cap > used) ? cap - used : 0;
          if (32'(size) <= room) begin
            off = 32'(header) + used;
            if (off > 32'(OFFSET_MAX)) off = 32'(OFFSET_MAX);
            g.page = p[PAGE_W-1:0];
            g.offset = off[OFFSET_W-1:0];
            page_use[p] = SIZE_W'(used + 32'(size));
            placed = 1'b1;
          end
        end
        if (!placed) begin
          if (open_pages < DEFAULT_MAX_PAGES) begin
            page_use[open_pages] = size;
            g.page = open_pages[PAGE_W-1:0];
            g.offset = {{(OFFSET_W-HDR_W){1'b0}}, header};
            g.opened = 1'b1;
            open_pages++;
          end else begin
            g.status = ST_NO_PAGE;
          end
        end
      end
      expected_grants.push_back(g);
    endfunction

    function void complain(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (expected_grants.size() == 0) begin
        complain($sformatf("unexpected beat: page %0d offset %0d opened %0d status %0d",
                           got.page, got.offset, got.opened, got.status));
        return;
      end
      want = expected_grants.pop_front();
      if (got.page !== want.page || got.offset !== want.offset ||
          got.opened !== want.opened || got.status !== want.status)
        complain($sformatf("expected page %0d offset %0d opened %0d status %0d, got %0d %0d %0d %0d",
                           want.page, want.offset, want.opened, want.status,
                           got.page, got.offset, got.opened, got.status));
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction

  endclass

endpackage

[tb/paged_bump_allocator_test.sv]
// bench for the paged bump allocator: directed and random requests under varied traffic
`default_nettype none

module paged_bump_allocator_test;

  import pba_pkg::*;
  import pba_grant_check_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = DEFAULT_MAX_PAGES + 8;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {
    TRAFFIC_STEADY,
    TRAFFIC_SENDER_GAPS,
    TRAFFIC_RECEIVER_STALLS,
    TRAFFIC_BOTH
  } traffic_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [SIZE_W-1:0]    in_request_size;
  logic                 out_valid;
  logic                 out_stall;
  logic [PAGE_W-1:0]    out_page_index;
  logic [OFFSET_W-1:0]  out_byte_offset;
  logic                 out_opened_page;
  logic [STATUS_W-1:0]  out_status;

  traffic_t     traffic;
  bit           hold_off_req;
  grant_checker sb;

  paged_bump_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_request_size (in_request_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_page_index  (out_page_index),
    .out_byte_offset (out_byte_offset),
    .out_opened_page (out_opened_page),
    .out_status      (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned sender_gap_pct();
    if (traffic == TRAFFIC_SENDER_GAPS) return 48;
    if (traffic == TRAFFIC_BOTH) return 23;
    return 0;
  endfunction

  function automatic int unsigned receiver_stall_pct();
    if (traffic == TRAFFIC_RECEIVER_STALLS) return 48;
    if (traffic == TRAFFIC_BOTH) return 23;
    return 0;
  endfunction

  // mostly small sizes, with zero, capacity edges and the full field range mixed in
  function automatic logic [SIZE_W-1:0] pick_size(int unsigned top_size);
    int unsigned       r;
    int unsigned       cap;
    logic [SIZE_W-1:0] v;
    r = $urandom_range(99);
    cap = sb.capacity();
    if (r < 8) v = SIZE_W'($urandom_range(8191));
    else if (r < 14) v = '0;
    else if (r < 19) v = SIZE_W'(cap);
    else if (r < 22) v = SIZE_W'(cap + 1);
    else v = SIZE_W'($urandom_range(top_size));
    return v;
  endfunction

  // leaves cfg_valid high, the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_write(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] ps, input logic [SIZE_W-1:0] hdr);
    write_reg(REG_PAGE_SIZE, ps);
    write_reg(REG_HEADER, hdr);
    cfg_valid = 1'b0;
  endtask

  task automatic send_request(input logic [SIZE_W-1:0] size);
    while (chance(sender_gap_pct())) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_request_size = size;
    do @(posedge clk); while (in_stall);
    sb.note_request(size);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    traffic = TRAFFIC_STEADY;
    send_request(13'd0);       // zero bytes into empty page 0
    send_request(13'd4072);    // fills page 0 exactly
    send_request(13'd4073);    // one past capacity
    send_request(13'd8191);
    send_request(13'd0);       // offset saturates on the full page
    send_request(13'd1);       // opens page 1
    send_request(13'd100);
    wait_drained();
    // spare indices are ignored
    write_reg(REG_SPARE_A, 13'h1555);
    write_reg(REG_SPARE_B, 13'h0AAA);
    cfg_valid = 1'b0;
    send_request(13'd7);
    wait_drained();
    set_config(13'd8191, 13'd255);   // clamps to the page limit
    send_request(13'd3841);    // page 0 overfull now, page 1 short, opens page 2
    send_request(13'd3842);
    send_request(13'd3733);
    send_request(13'd1);
    wait_drained();
    set_config(13'd64, 13'h1FFF);    // header above page size: no room at all
    send_request(13'd0);
    send_request(13'd1);
    wait_drained();
    set_config(13'd0, 13'd0);
    send_request(13'd0);
    send_request(13'h1FFF);
    wait_drained();
  endtask

  task automatic run_phase(input traffic_t mode, input logic [SIZE_W-1:0] ps,
                           input logic [SIZE_W-1:0] hdr, input int unsigned count,
                           input int unsigned top_size, input bit hold_off);
    set_config(ps, hdr);
    traffic = mode;
    if (hold_off) hold_off_req = 1'b1;
    repeat (count) send_request(pick_size(top_size));
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_grant('{out_page_index, out_byte_offset, out_opened_page, out_status});
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = chance(receiver_stall_pct());
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL paged_bump_allocator");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_request_size = '0;
    traffic = TRAFFIC_STEADY;
    hold_off_req = 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    run_phase(TRAFFIC_STEADY,          13'd4096, 13'd24,  180, 120, 1'b0);
    run_phase(TRAFFIC_SENDER_GAPS,     13'd2048, 13'd0,   180, 200, 1'b0);
    run_phase(TRAFFIC_RECEIVER_STALLS, 13'd8191, 13'd255, 160, 60,  1'b1);
    // tiny pages so the pool runs out
    run_phase(TRAFFIC_BOTH,            13'd96,   13'd90,  160, 8,   1'b0);
    run_phase(TRAFFIC_STEADY,          13'd3000, 13'd17,  160, 100, 1'b0);
    run_phase(TRAFFIC_BOTH,            13'd4096, 13'd0,   160, 40,  1'b0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS paged_bump_allocator");
    else
      $display("FAIL paged_bump_allocator");
    $finish;
  end

endmodule

`default_nettype wire
